// ----- design/nna_pkg.sv -----
`default_nettype none
package nna_pkg;
	localparam int DEF_WIDTH = 32;
	localparam int DATA_W = 32;

	typedef enum logic [3:0] {
		FN_ISZERO = 4'd0, FN_SUCC = 4'd1, FN_ADD = 4'd2, FN_EQUAL = 4'd3,
		FN_GREATER = 4'd4, FN_SUB = 4'd5, FN_MUL = 4'd6, FN_QUOT = 4'd7,
		FN_REM = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NA = 2'd1, ST_OVF = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CL_DIRECT = 3'd0, CL_MUL = 3'd1, CL_DIV = 3'd2
	} op_class_t;

	// one queued operation between front and back
	typedef struct packed {
		op_class_t cls;
		logic rem_sel;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] r;
		status_t st;
	} op_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		status_t st;
	} res_t;
endpackage
`default_nettype wire

// ----- design/natural_number_alu_core.sv -----
// Path: push is registered in the front stage, queued in the FIFO and registered again in the back
// end's result register before empty goes low; quotient/remainder also run the bit-serial divider.
// Throughput: one item per cycle while results are popped, except divide: the divider takes no new item until done.
// A 4-entry queue separates front classification from back execution.
// Reset: arst_n asynchronous active low, empties all queues and stages.
`default_nettype none
module natural_number_alu_core #(
	parameter int WIDTH = nna_pkg::DEF_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [3:0] func,
	input  wire logic [nna_pkg::DATA_W-1:0] x_value,
	input  wire logic [nna_pkg::DATA_W-1:0] y_value,
	output logic empty,
	input  wire logic pop,
	output logic [nna_pkg::DATA_W-1:0] result_value,
	output logic [1:0] status
);
	import nna_pkg::*;
	op_t f_op, q_op;
	res_t res;
	logic f_v, f_r, q_v, q_r, o_v, in_r;

	assign full = !in_r;
	assign empty = !o_v;
	assign result_value = res.value;
	assign status = res.st;

	nna_front #(.WIDTH(WIDTH)) u_front (
		.clk, .arst_n, .in_valid(push), .in_ready(in_r), .func, .x_value, .y_value,
		.out_valid(f_v), .out_ready(f_r), .out_op(f_op)
	);

	nna_fifo #(.W($bits(op_t)), .DEPTH(4)) u_fifo (
		.clk, .arst_n, .wr_valid(f_v), .wr_ready(f_r), .wr_data(f_op),
		.rd_valid(q_v), .rd_ready(q_r), .rd_data(q_op)
	);

	nna_back #(.WIDTH(WIDTH)) u_back (
		.clk, .arst_n, .in_valid(q_v), .in_ready(q_r), .in_op(q_op),
		.out_valid(o_v), .out_ready(pop), .out_res(res)
	);
endmodule
`default_nettype wire

// ----- design/nna_front.sv -----
`default_nettype none
module nna_front #(
	parameter int WIDTH = nna_pkg::DEF_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [3:0] func,
	input  wire logic [nna_pkg::DATA_W-1:0] x_value,
	input  wire logic [nna_pkg::DATA_W-1:0] y_value,
	output logic out_valid,
	input  wire logic out_ready,
	output nna_pkg::op_t out_op
);
	import nna_pkg::*;
	localparam int EW = (WIDTH < DATA_W) ? WIDTH : DATA_W;
	localparam logic [DATA_W:0] MASK = (DATA_W+1)'((65'd1 << EW) - 65'd1);

	op_t op_c, op_s1;
	logic v_s1;
	logic [DATA_W:0] x, y, sum, inc;

	assign in_ready = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_op = op_s1;

	always_comb begin
		x = {1'b0, x_value} & MASK;
		y = {1'b0, y_value} & MASK;
		sum = x + y;
		inc = x + 1'b1;
		op_c.cls = CL_DIRECT;
		op_c.rem_sel = 1'b0;
		op_c.x = x[DATA_W-1:0];
		op_c.y = y[DATA_W-1:0];
		op_c.r = '0;
		op_c.st = ST_OK;
		case (func)
			FN_ISZERO: op_c.r = {{(DATA_W-1){1'b0}}, x == '0};
			FN_SUCC: begin
				op_c.r = inc[DATA_W-1:0] & MASK[DATA_W-1:0];
				if (inc > MASK) op_c.st = ST_OVF;
			end
			FN_ADD: begin
				op_c.r = sum[DATA_W-1:0] & MASK[DATA_W-1:0];
				if (sum > MASK) op_c.st = ST_OVF;
			end
			FN_EQUAL: op_c.r = {{(DATA_W-1){1'b0}}, x == y};
			FN_GREATER: op_c.r = {{(DATA_W-1){1'b0}}, x > y};
			FN_SUB: begin
				if (y > x) op_c.st = ST_NA;
				else op_c.r = DATA_W'(x - y);
			end
			FN_MUL: op_c.cls = CL_MUL;
			FN_QUOT, FN_REM: begin
				op_c.rem_sel = (func == FN_REM);
				if (y == '0) op_c.st = ST_NA;
				else op_c.cls = CL_DIV;
			end
			default: op_c.st = ST_NA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) op_s1 <= op_c;
	end
endmodule
`default_nettype wire

// ----- design/nna_fifo.sv -----
`default_nettype none
module nna_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic wr_ready,
	input  wire logic [W-1:0] wr_data,
	output logic rd_valid,
	input  wire logic rd_ready,
	output logic [W-1:0] rd_data
);
	localparam int AW = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

// ----- design/nna_back.sv -----
`default_nettype none
module nna_back #(
	parameter int WIDTH = nna_pkg::DEF_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire nna_pkg::op_t in_op,
	output logic out_valid,
	input  wire logic out_ready,
	output nna_pkg::res_t out_res
);
	import nna_pkg::*;
	localparam int EW = (WIDTH < DATA_W) ? WIDTH : DATA_W;
	localparam logic [2*DATA_W-1:0] MASK = (2*DATA_W)'((65'd1 << EW) - 65'd1);
	localparam int CW = $clog2(DATA_W+1);

	logic busy_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic [DATA_W-1:0] quo_q, div_q;
	logic [DATA_W:0] rem_acc_q, trial;
	logic ov_q;
	res_t res_q;
	logic [2*DATA_W-1:0] prod;
	logic accept, slot_free, finish;

	// direct and multiply ops pass straight to the result register; div runs one quotient bit per cycle
	assign slot_free = !ov_q || out_ready;
	assign in_ready = !busy_q && slot_free;
	assign accept = in_valid && in_ready;
	assign finish = busy_q && cnt_q == '0 && slot_free;
	assign out_valid = ov_q;
	assign out_res = res_q;
	assign prod = in_op.x * in_op.y;
	assign trial = {rem_acc_q[DATA_W-1:0], quo_q[DATA_W-1]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (accept && in_op.cls == CL_DIV) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DATA_W);
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if ((accept && in_op.cls != CL_DIV) || finish) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (in_op.cls)
				CL_MUL: begin
					res_q.value <= prod[DATA_W-1:0] & MASK[DATA_W-1:0];
					res_q.st <= (prod > MASK) ? ST_OVF : ST_OK;
				end
				CL_DIV: begin
					quo_q <= in_op.x;
					div_q <= in_op.y;
					rem_acc_q <= '0;
					rem_q <= in_op.rem_sel;
				end
				default: res_q <= '{value: in_op.r, st: in_op.st};
			endcase
		end else if (busy_q && cnt_q != '0) begin
			if (!trial[DATA_W]) rem_acc_q <= {1'b0, trial[DATA_W-1:0]};
			else rem_acc_q <= {1'b0, rem_acc_q[DATA_W-2:0], quo_q[DATA_W-1]};
			quo_q <= {quo_q[DATA_W-2:0], !trial[DATA_W]};
		end else if (finish) begin
			res_q.value <= rem_q ? rem_acc_q[DATA_W-1:0] : quo_q;
			res_q.st <= ST_OK;
		end
	end
endmodule
`default_nettype wire

// ----- design/nna_checker.sv -----
`default_nettype none
module nna_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire logic [31:0] result_value,
	input wire logic [1:0] status
);
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status != 2'd3) else $error("bad status");
	a_na_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == 2'd1) |-> result_value == '0) else $error("na nonzero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_value) && $stable(status)))
		else $error("result dropped");
endmodule

bind natural_number_alu_core nna_checker u_chk (
	.clk, .arst_n, .empty, .pop, .result_value, .status
);
`default_nettype wire
